@@ hdl/byte_position_change_monitor_unit_macros.svh @@
// Assertion macros for the byte position change monitor.
`ifndef BYTE_POSITION_CHANGE_MONITOR_UNIT_MACROS_SVH
`define BYTE_POSITION_CHANGE_MONITOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// a holds at an edge, so b holds at the same edge
`define BPCM_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// a holds at an edge, so b holds at the next edge
`define BPCM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define BPCM_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define BPCM_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

@@ hdl/bpcm_pkg.sv @@
// Shared types and codes of the byte position change monitor.
package bpcm_pkg;
	// request kinds
	localparam logic [2:0] ACT_START  = 3'd0;
	localparam logic [2:0] ACT_BYTE   = 3'd1;
	localparam logic [2:0] ACT_QUERY  = 3'd2;
	localparam logic [2:0] ACT_LOG    = 3'd3;
	localparam logic [2:0] ACT_TOTALS = 3'd4;

	// what the current frame does with its bytes
	localparam logic [1:0] MODE_IGNORE  = 2'd0;
	localparam logic [1:0] MODE_LOAD    = 2'd1;
	localparam logic [1:0] MODE_COMPARE = 2'd2;

	// position classes
	localparam logic [1:0] CLASS_STILL = 2'd0;
	localparam logic [1:0] CLASS_RARE  = 2'd1;
	localparam logic [1:0] CLASS_BUSY  = 2'd2;

	// register byte address
	localparam logic [0:0] ADDR_WATCHED = 1'b0;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

	// frame-level state seen by the byte pipeline
	typedef struct packed {
		logic [1:0]  mode;
		logic [47:0] delta;
		logic [31:0] frames;
		logic [31:0] accepted;
		logic [15:0] cap_min;
		logic [15:0] cap_max;
		logic [15:0] org_min;
		logic [15:0] org_max;
	} frame_state_t;
endpackage

@@ hdl/bpcm_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with write-to-read bypass.
module bpcm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, a same-cycle write to the entry is forwarded
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end
endmodule

@@ hdl/bpcm_frame.sv @@
// Frame-start bookkeeping: counters, length bounds, window, mode and delta.
module bpcm_frame #(
	parameter int WINDOW = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start_ev,
	input  logic [63:0]               ts,
	input  logic [47:0]               src,
	input  logic                      recog,
	input  logic [15:0]               cap,
	input  logic [15:0]               org,
	input  logic [47:0]               watched,
	output bpcm_pkg::frame_state_t    fs,
	output logic [$clog2(WINDOW+1)-1:0] window
);
	import bpcm_pkg::*;

	localparam int WW = $clog2(WINDOW + 1);

	logic          first_q;
	logic [63:0]   start_q;
	logic [WW-1:0] window_q;
	frame_state_t  fs_q;

	logic [63:0]   start_new;
	logic [63:0]   diff;
	logic [47:0]   delta;
	logic [WW-1:0] w;
	logic          match;

	// delta from the first nonzero timestamp, clamped to 48 bits
	always_comb begin
		start_new = (start_q == 64'd0) ? ts : start_q;
		diff      = ts - start_new;
		if (ts < start_new) begin
			delta = 48'd0;
		end else if (diff[63:48] != 16'd0) begin
			delta = SAT48;
		end else begin
			delta = diff[47:0];
		end
		w     = ({1'b0, cap} < 17'(WINDOW)) ? cap[WW-1:0] : WW'(WINDOW);
		match = (src == watched) && recog;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b0;
			start_q     <= 64'd0;
			window_q    <= '0;
			fs_q.mode     <= MODE_IGNORE;
			fs_q.delta    <= 48'd0;
			fs_q.frames   <= 32'd0;
			fs_q.accepted <= 32'd0;
			fs_q.cap_min  <= 16'hFFFF;
			fs_q.cap_max  <= 16'd0;
			fs_q.org_min  <= 16'hFFFF;
			fs_q.org_max  <= 16'd0;
		end else if (start_ev) begin
			if (fs_q.frames != SAT32) fs_q.frames <= fs_q.frames + 32'd1;
			start_q   <= start_new;
			fs_q.mode <= MODE_IGNORE;
			if (match) begin
				if (fs_q.accepted != SAT32) fs_q.accepted <= fs_q.accepted + 32'd1;
				if (cap < fs_q.cap_min) fs_q.cap_min <= cap;
				if (cap > fs_q.cap_max) fs_q.cap_max <= cap;
				if (org < fs_q.org_min) fs_q.org_min <= org;
				if (org > fs_q.org_max) fs_q.org_max <= org;
				fs_q.delta <= delta;
				if (!first_q) begin
					first_q   <= 1'b1;
					window_q  <= w;
					fs_q.mode <= MODE_LOAD;
				end else begin
					if (w < window_q) window_q <= w;
					fs_q.mode <= MODE_COMPARE;
				end
			end
		end
	end

	assign fs     = fs_q;
	assign window = window_q;
endmodule

@@ hdl/byte_position_change_monitor_unit.sv @@
// Top level of the byte position change monitor.
// Requests enter on the s_ group: tuser carries the kind (frame start, frame
// byte, position query, log read, totals query) and the length kind, tdata the
// frame fields. Frame starts and frame bytes give no result; each query gives
// one result on the m_ group. One request is taken per cycle while s_tready
// is high. Reference bytes, change counts and the change log sit in synchronous
// RAMs that are read when a request is taken and written back from stage 1;
// the RAM bypass forwards a write to a read of the same entry, so back-to-back
// bytes at one position are counted correctly. The user must set the watched
// address through the APB port only while the block is idle; the block does
// not enforce this. Reset clears the frame counters, length bounds, frame
// state and the count valid bits at once; no clearing pass is needed. When
// the receiver holds tready low with a result pending, the pipeline freezes
// and s_tready drops in the same cycle; nothing is lost or repeated.
`include "byte_position_change_monitor_unit_macros.svh"
module byte_position_change_monitor_unit #(
	parameter int WINDOW    = 256,
	parameter int LOG_DEPTH = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// timestamp, source_address, recognized, captured_length, original_length,
	// position, byte_value, log_index, zero pad
	input  logic [167:0] s_tdata,
	// action, length_kind
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// change_count, byte_class, log_valid, log_time, log_old, log_new,
	// frames_seen, matched_frames, window_size, length_low, length_high, zero pad
	output logic [207:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [0:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	import bpcm_pkg::*;

	localparam int PD = (WINDOW < 256) ? WINDOW : 256;
	localparam int AW = $clog2(PD);
	localparam int LN = PD * LOG_DEPTH;
	localparam int LA = $clog2(LN);
	localparam int WW = $clog2(WINDOW + 1);

	// configuration
	logic [47:0] watched_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_q <= 48'd0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_WATCHED) begin
			watched_q <= pwdata[47:0];
		end
	end
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_WATCHED) ? {16'd0, watched_q} : 64'd0;

	// handshake and stage 1 registers
	logic advance, acc, fire;
	logic out_vld_q;
	logic vld_s1;
	logic [2:0]  act_s1;
	logic [63:0] ts_s1;
	logic [47:0] src_s1;
	logic        recog_s1;
	logic [15:0] cap_s1, org_s1;
	logic [7:0]  pos_s1, byte_s1;
	logic [5:0]  idx_s1;
	logic        kind_s1;

	assign advance  = !out_vld_q || m_tready;
	assign s_tready = advance;
	assign acc      = s_tvalid && advance;
	assign fire     = vld_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1   <= s_tuser[2:0];
			kind_s1  <= s_tuser[3];
			ts_s1    <= s_tdata[63:0];
			src_s1   <= s_tdata[111:64];
			recog_s1 <= s_tdata[112];
			cap_s1   <= s_tdata[128:113];
			org_s1   <= s_tdata[144:129];
			pos_s1   <= s_tdata[152:145];
			byte_s1  <= s_tdata[160:153];
			idx_s1   <= s_tdata[166:161];
		end
	end

	// frame bookkeeping
	frame_state_t  fs;
	logic [WW-1:0] window;
	bpcm_frame #(.WINDOW(WINDOW)) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.start_ev(fire && act_s1 == ACT_START),
		.ts      (ts_s1),
		.src     (src_s1),
		.recog   (recog_s1),
		.cap     (cap_s1),
		.org     (org_s1),
		.watched (watched_q),
		.fs      (fs),
		.window  (window)
	);

	// memory read addresses from the incoming request
	logic [AW-1:0] rd_pos;
	logic [LA-1:0] rd_log_addr;
	assign rd_pos      = s_tdata[145+AW-1:145];
	assign rd_log_addr = LA'(32'(s_tdata[152:145]) * LOG_DEPTH + 32'(s_tdata[166:161]));

	// write-back controls
	logic          ref_we, cnt_we, log_we;
	logic [7:0]    ref_rd;
	logic [31:0]   cnt_rd, cnt_s1, cnt_next;
	logic [63:0]   log_rd;
	logic [LA-1:0] wr_log_addr;
	logic          pos_ok, in_win, differs;

	bpcm_ram #(.DEPTH(PD), .WIDTH(8)) u_ref (
		.clk(clk), .we(ref_we), .waddr(pos_s1[AW-1:0]), .wdata(byte_s1),
		.re(acc), .raddr(rd_pos), .rdata(ref_rd)
	);

	bpcm_ram #(.DEPTH(PD), .WIDTH(32)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(pos_s1[AW-1:0]), .wdata(cnt_next),
		.re(acc), .raddr(rd_pos), .rdata(cnt_rd)
	);

	bpcm_ram #(.DEPTH(LN), .WIDTH(64)) u_log (
		.clk(clk), .we(log_we), .waddr(wr_log_addr),
		.wdata({byte_s1, ref_rd, fs.delta}),
		.re(acc), .raddr(rd_log_addr), .rdata(log_rd)
	);

	// count valid bits: an entry not yet written reads as zero
	logic [PD-1:0] cvld_q;
	logic          cvld_rd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q    <= '0;
			cvld_rd_q <= 1'b0;
		end else begin
			if (cnt_we) cvld_q[pos_s1[AW-1:0]] <= 1'b1;
			if (acc) cvld_rd_q <= (cnt_we && pos_s1[AW-1:0] == rd_pos) || cvld_q[rd_pos];
		end
	end

	// byte compare and update
	always_comb begin
		cnt_s1      = cvld_rd_q ? cnt_rd : 32'd0;
		cnt_next    = (cnt_s1 == SAT32) ? cnt_s1 : cnt_s1 + 32'd1;
		pos_ok      = {1'b0, pos_s1} < 9'(PD);
		in_win      = fs.mode != MODE_IGNORE && pos_ok && 32'(pos_s1) < 32'(window);
		differs     = ref_rd != byte_s1;
		ref_we      = fire && act_s1 == ACT_BYTE && in_win &&
		              (fs.mode == MODE_LOAD || (fs.mode == MODE_COMPARE && differs));
		cnt_we      = fire && act_s1 == ACT_BYTE && in_win &&
		              fs.mode == MODE_COMPARE && differs;
		log_we      = cnt_we && cnt_s1 < 32'(LOG_DEPTH);
		wr_log_addr = LA'(32'(pos_s1[AW-1:0]) * LOG_DEPTH + cnt_s1);
	end

	// result assembly
	logic [31:0] o_count;
	logic [1:0]  o_class;
	logic        o_lvalid;
	logic [47:0] o_ltime;
	logic [7:0]  o_lold, o_lnew;
	logic [31:0] o_frames, o_matched;
	logic [8:0]  o_window;
	logic [15:0] o_low, o_high;
	logic        is_result;

	always_comb begin
		o_count = 32'd0; o_class = CLASS_STILL; o_lvalid = 1'b0; o_ltime = 48'd0;
		o_lold = 8'd0; o_lnew = 8'd0; o_frames = 32'd0; o_matched = 32'd0;
		o_window = 9'd0; o_low = 16'd0; o_high = 16'd0;
		is_result = 1'b0;
		case (act_s1)
			ACT_QUERY: begin
				is_result = 1'b1;
				if (pos_ok) begin
					o_count = cnt_s1;
					if (cnt_s1 == 32'd0) o_class = CLASS_STILL;
					else if (cnt_s1 > (fs.accepted >> 3)) o_class = CLASS_BUSY;
					else o_class = CLASS_RARE;
				end
			end
			ACT_LOG: begin
				is_result = 1'b1;
				if (pos_ok && 32'(idx_s1) < 32'(LOG_DEPTH) && 32'(idx_s1) < cnt_s1) begin
					o_lvalid = 1'b1;
					o_ltime  = log_rd[47:0];
					o_lold   = log_rd[55:48];
					o_lnew   = log_rd[63:56];
				end
			end
			ACT_TOTALS: begin
				is_result = 1'b1;
				o_frames  = fs.frames;
				o_matched = fs.accepted;
				o_window  = 9'(window);
				o_low     = kind_s1 ? fs.org_min : fs.cap_min;
				o_high    = kind_s1 ? fs.org_max : fs.cap_max;
			end
			default: is_result = 1'b0;
		endcase
	end

	// output register
	logic [207:0] out_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= fire && is_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_result) begin
			out_data_q <= {4'd0, o_high, o_low, o_window, o_matched, o_frames,
			               o_lnew, o_lold, o_ltime, o_lvalid, o_class, o_count};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// checks
	`BPCM_ASSERT_IMPLY(a_cnt_needs_compare, clk, arst_n, cnt_we, fs.mode == MODE_COMPARE && ref_we, "count written outside a compared frame")
	`BPCM_ASSERT_IMPLY(a_log_needs_cnt, clk, arst_n, log_we, cnt_we && cnt_s1 < 32'(LOG_DEPTH), "log written without a counted change")
	`BPCM_ASSERT_NEXT(a_result_on_fire, clk, arst_n, fire && is_result, m_tvalid, "query finished without a result")
endmodule
